// ===== rtl/core/fpc_pkg.sv =====
// ----------------------------------------------------------------------------
// fpc_pkg
// shared types and constants for the framed packet checker
// ----------------------------------------------------------------------------
package fpc_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned COUNT_W = 32;

    // header layout and framing limits
    localparam logic [COUNT_W-1:0] HEADER_BYTES = COUNT_W'(7);
    localparam logic [COUNT_W-1:0] MIN_PACKET   = COUNT_W'(9);
    localparam logic [COUNT_W-1:0] HASH_BYTES   = COUNT_W'(2);
    localparam logic [COUNT_W-1:0] SIZE_FIRST   = COUNT_W'(2);
    localparam logic [COUNT_W-1:0] SIZE_LAST    = COUNT_W'(5);
    localparam logic [COUNT_W-1:0] ID_OFFSET    = COUNT_W'(6);

    typedef enum logic [1:0] {
        STATUS_GOOD    = 2'd0,
        STATUS_SHORT   = 2'd1,
        STATUS_BAD_SUM = 2'd2
    } status_t;

    // first member sits in the top bits, so status ends up lowest
    typedef struct packed {
        logic [COUNT_W-1:0] packet_length;
        logic               id_match;
        logic [BYTE_W-1:0]  packet_id;
        status_t            status;
    } fpc_result_t;

    localparam int unsigned RESULT_W    = $bits(fpc_result_t);
    localparam int unsigned OUT_TDATA_W = ((RESULT_W + 7) / 8) * 8;

endpackage

// ===== rtl/core/fpc_tracker.sv =====
// ----------------------------------------------------------------------------
// fpc_tracker
// per-packet state: byte count, size field, id, fletcher-style sums and tail bytes
// ----------------------------------------------------------------------------
module fpc_tracker
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step,
    input  logic [fpc_pkg::BYTE_W-1:0]    rx_byte,
    input  logic [fpc_pkg::BYTE_W-1:0]    expected_pid,
    output logic                          done,
    output fpc_pkg::fpc_result_t          result
);

    logic [fpc_pkg::COUNT_W-1:0] count_reg;
    logic [fpc_pkg::COUNT_W-1:0] count_next;
    logic [fpc_pkg::COUNT_W-1:0] size_reg;
    logic [fpc_pkg::COUNT_W-1:0] size_next;
    logic [fpc_pkg::BYTE_W-1:0]  id_reg;
    logic [fpc_pkg::BYTE_W-1:0]  id_next;
    logic [fpc_pkg::BYTE_W-1:0]  sum_a_reg;
    logic [fpc_pkg::BYTE_W-1:0]  sum_a_next;
    logic [fpc_pkg::BYTE_W-1:0]  sum_b_reg;
    logic [fpc_pkg::BYTE_W-1:0]  sum_b_next;
    logic [fpc_pkg::BYTE_W-1:0]  tail0_reg;
    logic [fpc_pkg::BYTE_W-1:0]  tail1_reg;
    fpc_pkg::status_t            status;

    always_comb
    begin
        size_next  = size_reg;
        id_next    = id_reg;
        sum_a_next = sum_a_reg;
        sum_b_next = sum_b_reg;
        if (count_reg >= fpc_pkg::SIZE_FIRST && count_reg <= fpc_pkg::SIZE_LAST)
        begin
            size_next = {size_reg[fpc_pkg::COUNT_W-fpc_pkg::BYTE_W-1:0], rx_byte};
        end
        if (count_reg == fpc_pkg::ID_OFFSET)
        begin
            id_next = rx_byte;
        end
        // byte leaving the two-deep delay line joins the sums
        if (count_reg >= fpc_pkg::HASH_BYTES)
        begin
            sum_a_next = sum_a_reg + tail0_reg;
            sum_b_next = sum_b_reg + sum_a_next;
        end
        // count saturates at all ones
        count_next = (&count_reg) ? count_reg : count_reg + 1'b1;
        done = (count_next >= fpc_pkg::HEADER_BYTES) && (count_next >= size_next);

        if (count_next < fpc_pkg::MIN_PACKET)
        begin
            status = fpc_pkg::STATUS_SHORT;
        end
        else if (tail1_reg == sum_a_next && rx_byte == sum_b_next)
        begin
            status = fpc_pkg::STATUS_GOOD;
        end
        else
        begin
            status = fpc_pkg::STATUS_BAD_SUM;
        end

        result.status        = status;
        result.packet_id     = id_next;
        result.id_match      = (status == fpc_pkg::STATUS_GOOD) && (id_next == expected_pid);
        result.packet_length = count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            size_reg  <= '0;
            id_reg    <= '0;
            sum_a_reg <= '0;
            sum_b_reg <= '0;
            tail0_reg <= '0;
            tail1_reg <= '0;
        end
        else if (step)
        begin
            if (done)
            begin
                count_reg <= '0;
                size_reg  <= '0;
                id_reg    <= '0;
                sum_a_reg <= '0;
                sum_b_reg <= '0;
                tail0_reg <= '0;
                tail1_reg <= '0;
            end
            else
            begin
                count_reg <= count_next;
                size_reg  <= size_next;
                id_reg    <= id_next;
                sum_a_reg <= sum_a_next;
                sum_b_reg <= sum_b_next;
                tail0_reg <= tail1_reg;
                tail1_reg <= rx_byte;
            end
        end
    end

endmodule

// ===== rtl/core/framed_packet_checker_core.sv =====
// ----------------------------------------------------------------------------
// framed_packet_checker_core
// byte-wise receive check of length-framed packets with a fletcher-style trailer
// ----------------------------------------------------------------------------
//  channel   direction  width  content
//  s_axis    in         8      rx_byte
//  m_axis    out        48     status, packet_id, id_match, packet_length
//  cfg       in         8      expected_pid, written when cfg_we is high
//
//  one byte per cycle while the sink takes results; a result is presented
//  once its last byte has passed the input register, then the result register.
//  the sums and size compare sit in one stage between those two registers.
//  a result held by the sink stops the tracker; the input register still takes
//  one byte if it is empty, then s_axis_tready stays low until the sink takes the result.
//  reset clears the packet state and expected_pid to zero.
// ----------------------------------------------------------------------------
module framed_packet_checker_core
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [fpc_pkg::BYTE_W-1:0]          s_axis_tdata,   // [7:0] rx_byte
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [1:0] status, [9:2] packet_id, [10] id_match, [42:11] packet_length, rest zero
    output logic [fpc_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    input  logic                                cfg_we,
    input  logic [fpc_pkg::BYTE_W-1:0]          cfg_wdata
);

    logic                         in_valid_reg;
    logic [fpc_pkg::BYTE_W-1:0]   in_byte_reg;
    logic                         out_valid_reg;
    fpc_pkg::fpc_result_t         out_result_reg;
    logic [fpc_pkg::BYTE_W-1:0]   pid_reg;
    logic                         out_free;
    logic                         advance;
    logic                         done;
    fpc_pkg::fpc_result_t         result;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign advance       = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || advance;

    fpc_tracker u_tracker
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (advance),
        .rx_byte      (in_byte_reg),
        .expected_pid (pid_reg),
        .done         (done),
        .result       (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pid_reg       <= '0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (out_free)
            begin
                out_valid_reg <= advance && done;
            end
            if (cfg_we)
            begin
                pid_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_byte_reg <= s_axis_tdata;
        end
        if (advance && done)
        begin
            out_result_reg <= result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(fpc_pkg::OUT_TDATA_W - fpc_pkg::RESULT_W){1'b0}},
                            out_result_reg};

endmodule

// ===== rtl/core/fpc_checker.sv =====
// ----------------------------------------------------------------------------
// fpc_checker
// port-level checks on results of the framed packet checker
// ----------------------------------------------------------------------------
module fpc_checker
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    input  logic [fpc_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);

    logic [1:0]                  chk_status;
    logic                        chk_match;
    logic [fpc_pkg::COUNT_W-1:0] chk_length;

    assign chk_status = m_axis_tdata[1:0];
    assign chk_match  = m_axis_tdata[10];
    assign chk_length = m_axis_tdata[42:11];

    // stalled transaction holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // a packet never ends before the header is complete
    a_min_len: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> chk_length >= fpc_pkg::HEADER_BYTES)
        else $error("packet shorter than header");

    // short status exactly when the packet is below the minimum size
    a_short: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> ((chk_length < fpc_pkg::MIN_PACKET) ==
                           (chk_status == fpc_pkg::STATUS_SHORT)))
        else $error("short status disagrees with length");

    // id match only on a good packet
    a_match: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && chk_match |-> chk_status == fpc_pkg::STATUS_GOOD)
        else $error("id match on bad packet");

endmodule

bind framed_packet_checker_core fpc_checker u_fpc_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
